@@ sv/iiea_pkg.sv @@
// Package for the indexed insert/erase word array.
// Holds sizes, operation and status codes, and the command/status structs
// shared by the controller, the datapath and the top level.
package iiea_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;

   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = $clog2(DEPTH);

   // Operation codes carried in func.
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_FRONT  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_BACK   = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd7;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // Read address sources.
   localparam logic [2:0] RA_ZERO   = 3'd0;
   localparam logic [2:0] RA_CNT_M1 = 3'd1;
   localparam logic [2:0] RA_IDX    = 3'd2;
   localparam logic [2:0] RA_IDX_P1 = 3'd3;
   localparam logic [2:0] RA_PTR_M1 = 3'd4;
   localparam logic [2:0] RA_PTR_P1 = 3'd5;

   // Write address sources.
   localparam logic [1:0] WA_CNT    = 2'd0;
   localparam logic [1:0] WA_IDX    = 2'd1;
   localparam logic [1:0] WA_PTR_P1 = 2'd2;
   localparam logic [1:0] WA_PTR_M1 = 2'd3;

   // Shift pointer updates.
   localparam logic [2:0] PTR_HOLD    = 3'd0;
   localparam logic [2:0] PTR_CNT_M1  = 3'd1;
   localparam logic [2:0] PTR_IDX_P1  = 3'd2;
   localparam logic [2:0] PTR_DEC     = 3'd3;
   localparam logic [2:0] PTR_INC     = 3'd4;

   // Length updates.
   localparam logic [1:0] CNT_HOLD  = 2'd0;
   localparam logic [1:0] CNT_INC   = 2'd1;
   localparam logic [1:0] CNT_DEC   = 2'd2;
   localparam logic [1:0] CNT_CLEAR = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      logic [2:0]          rd_sel;
      logic                wr_en;
      logic [1:0]          wr_sel;
      logic                wr_from_rdata;
      logic [2:0]          ptr_op;
      logic [1:0]          cnt_op;
      logic                note_en;
      logic [STATUS_W-1:0] status;
      logic                use_rdata;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              idx_gt_cnt;
      logic              idx_ge_cnt;
      logic              idx_eq_cnt;
      logic              idx_last;
      logic              ptr_eq_idx;
      logic              ptr_last;
      logic              rsp_free;
   } sts_type;

endpackage

@@ sv/iiea_req_if.sv @@
// Request channel of the indexed insert/erase word array.
// Depends on iiea_pkg for the field widths.
interface iiea_req_if;
   logic                          valid;
   logic                          ready;
   logic [iiea_pkg::FUNC_W-1:0]   func;
   logic [iiea_pkg::INDEX_W-1:0]  index;
   logic [iiea_pkg::DATA_W-1:0]   value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);
endinterface

@@ sv/iiea_rsp_if.sv @@
// Response channel of the indexed insert/erase word array.
// Depends on iiea_pkg for the field widths.
interface iiea_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iiea_pkg::DATA_W-1:0]    data;
   logic [iiea_pkg::STATUS_W-1:0]  status;
   logic [iiea_pkg::LEN_W-1:0]     length;
   logic                           is_empty;

   modport source (output valid, output data, output status, output length,
                   output is_empty, input ready);
   modport sink   (input valid, input data, input status, input length,
                   input is_empty, output ready);
endinterface

@@ sv/indexed_insert_erase_array.sv @@
// Top level of the indexed insert/erase word array.
// Depends on iiea_pkg, iiea_req_if, iiea_rsp_if, iiea_ctrl and iiea_dpath.
//
//   Channel   Direction  Payload                          Handshake
//   req_ch    in         func, index, value               valid/ready
//   rsp_ch    out        data, status, length, is_empty   valid/ready
//
// Most items go from acceptance through a check and a response state; an
// insert at index i that is not an append first moves words i and up one
// place, and an erase that is not of the last word moves words above i down:
// the word memory moves one word per cycle (one read and one write port).
// Reset is synchronous and empties the array; no clearing pass is needed.
// A new item is taken while the previous result waits in the output
// register; the block then stalls before loading the next result.
module indexed_insert_erase_array (
   input logic        clock,
   input logic        reset,
   iiea_req_if.sink   req_ch,
   iiea_rsp_if.source rsp_ch
);

   iiea_pkg::cmd_type cmd;
   iiea_pkg::sts_type sts;

   iiea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iiea_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_func     (req_ch.func),
      .req_index    (req_ch.index),
      .req_value    (req_ch.value),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_data     (rsp_ch.data),
      .rsp_status   (rsp_ch.status),
      .rsp_length   (rsp_ch.length),
      .rsp_is_empty (rsp_ch.is_empty)
   );

`ifndef SYNTH
   // Only one item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an item was in progress");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == iiea_pkg::ST_FULL)
         |-> (rsp_ch.length == iiea_pkg::LEN_W'(iiea_pkg::DEPTH)))
      else $error("full status reported below the depth");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == iiea_pkg::ST_EMPTY)
         |-> (rsp_ch.is_empty && rsp_ch.data == '0))
      else $error("empty status reported with stored words or data");
`endif

endmodule

@@ sv/iiea_ctrl.sv @@
// Controller state machine of the indexed insert/erase word array.
// Depends on iiea_pkg for codes and the command/status structs.
module iiea_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iiea_pkg::sts_type sts,
   output iiea_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SHUP  = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_SHDN  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.note_en = 1'b1;
            cmd.status  = iiea_pkg::ST_OK;
            state_in    = S_RESP;
            case (sts.func)
               iiea_pkg::FUNC_APPEND: begin
                  if (sts.full) begin
                     cmd.status = iiea_pkg::ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = iiea_pkg::WA_CNT;
                     cmd.cnt_op = iiea_pkg::CNT_INC;
                  end
               end
               iiea_pkg::FUNC_POP: begin
                  if (sts.empty) begin
                     cmd.status = iiea_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = iiea_pkg::RA_CNT_M1;
                     cmd.cnt_op    = iiea_pkg::CNT_DEC;
                     cmd.use_rdata = 1'b1;
                  end
               end
               iiea_pkg::FUNC_INSERT: begin
                  if (sts.idx_gt_cnt) begin
                     cmd.status = iiea_pkg::ST_BOUND;
                  end else if (sts.full) begin
                     cmd.status = iiea_pkg::ST_FULL;
                  end else if (sts.idx_eq_cnt) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = iiea_pkg::WA_IDX;
                     cmd.cnt_op = iiea_pkg::CNT_INC;
                  end else begin
                     // Move the tail up one word at a time, last word first.
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = iiea_pkg::RA_CNT_M1;
                     cmd.ptr_op = iiea_pkg::PTR_CNT_M1;
                     state_in   = S_SHUP;
                  end
               end
               iiea_pkg::FUNC_ERASE: begin
                  if (sts.idx_ge_cnt) begin
                     cmd.status = iiea_pkg::ST_BOUND;
                  end else if (sts.idx_last) begin
                     cmd.cnt_op = iiea_pkg::CNT_DEC;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = iiea_pkg::RA_IDX_P1;
                     cmd.ptr_op = iiea_pkg::PTR_IDX_P1;
                     state_in   = S_SHDN;
                  end
               end
               iiea_pkg::FUNC_READ: begin
                  if (sts.idx_ge_cnt) begin
                     cmd.status = iiea_pkg::ST_BOUND;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = iiea_pkg::RA_IDX;
                     cmd.use_rdata = 1'b1;
                  end
               end
               iiea_pkg::FUNC_FRONT: begin
                  if (sts.empty) begin
                     cmd.status = iiea_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = iiea_pkg::RA_ZERO;
                     cmd.use_rdata = 1'b1;
                  end
               end
               iiea_pkg::FUNC_BACK: begin
                  if (sts.empty) begin
                     cmd.status = iiea_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = iiea_pkg::RA_CNT_M1;
                     cmd.use_rdata = 1'b1;
                  end
               end
               default: begin
                  cmd.cnt_op = iiea_pkg::CNT_CLEAR;
               end
            endcase
         end
         S_SHUP: begin
            cmd.wr_en         = 1'b1;
            cmd.wr_sel        = iiea_pkg::WA_PTR_P1;
            cmd.wr_from_rdata = 1'b1;
            if (sts.ptr_eq_idx) begin
               state_in = S_PLACE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = iiea_pkg::RA_PTR_M1;
               cmd.ptr_op = iiea_pkg::PTR_DEC;
            end
         end
         S_PLACE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = iiea_pkg::WA_IDX;
            cmd.cnt_op = iiea_pkg::CNT_INC;
            state_in   = S_RESP;
         end
         S_SHDN: begin
            cmd.wr_en         = 1'b1;
            cmd.wr_sel        = iiea_pkg::WA_PTR_M1;
            cmd.wr_from_rdata = 1'b1;
            if (sts.ptr_last) begin
               cmd.cnt_op = iiea_pkg::CNT_DEC;
               state_in   = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = iiea_pkg::RA_PTR_P1;
               cmd.ptr_op = iiea_pkg::PTR_INC;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/iiea_dpath.sv @@
// Datapath of the indexed insert/erase word array: word memory, length,
// shift pointer and the response register. Depends on iiea_pkg.
module iiea_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  iiea_pkg::cmd_type               cmd,
   output iiea_pkg::sts_type               sts,
   input  logic [iiea_pkg::FUNC_W-1:0]     req_func,
   input  logic [iiea_pkg::INDEX_W-1:0]    req_index,
   input  logic [iiea_pkg::DATA_W-1:0]     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [iiea_pkg::DATA_W-1:0]     rsp_data,
   output logic [iiea_pkg::STATUS_W-1:0]   rsp_status,
   output logic [iiea_pkg::LEN_W-1:0]      rsp_length,
   output logic                            rsp_is_empty
);

   localparam int CW = iiea_pkg::CNT_W;
   localparam int AW = iiea_pkg::ADDR_W;

   iiea_pkg::word_type mem [iiea_pkg::DEPTH];

   logic [iiea_pkg::FUNC_W-1:0]   func_ff;
   logic [iiea_pkg::INDEX_W-1:0]  idx_ff;
   iiea_pkg::word_type            val_ff;
   iiea_pkg::word_type            rdata_ff;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 ptr_ff, ptr_in;
   logic [iiea_pkg::STATUS_W-1:0] status_ff;
   logic                          use_rdata_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [iiea_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [iiea_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [iiea_pkg::LEN_W-1:0]    rsp_length_ff;
   logic                          rsp_empty_ff;

   logic [CW-1:0]      idx_w, cnt_m1, idx_p1, ptr_m1, ptr_p1, rd_pos, wr_pos;
   iiea_pkg::word_type wr_data;

   assign idx_w  = CW'(idx_ff);
   assign cnt_m1 = cnt_ff - CW'(1);
   assign idx_p1 = idx_w + CW'(1);
   assign ptr_m1 = ptr_ff - CW'(1);
   assign ptr_p1 = ptr_ff + CW'(1);

   always_comb begin
      case (cmd.rd_sel)
         iiea_pkg::RA_CNT_M1: rd_pos = cnt_m1;
         iiea_pkg::RA_IDX:    rd_pos = idx_w;
         iiea_pkg::RA_IDX_P1: rd_pos = idx_p1;
         iiea_pkg::RA_PTR_M1: rd_pos = ptr_m1;
         iiea_pkg::RA_PTR_P1: rd_pos = ptr_p1;
         default:             rd_pos = '0;
      endcase
      case (cmd.wr_sel)
         iiea_pkg::WA_CNT:    wr_pos = cnt_ff;
         iiea_pkg::WA_IDX:    wr_pos = idx_w;
         iiea_pkg::WA_PTR_P1: wr_pos = ptr_p1;
         default:             wr_pos = ptr_m1;
      endcase
      wr_data = cmd.wr_from_rdata ? rdata_ff : val_ff;
   end

   // Simple dual-port word memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_pos[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_pos[AW-1:0]];
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         iiea_pkg::CNT_INC:   cnt_in = cnt_ff + CW'(1);
         iiea_pkg::CNT_DEC:   cnt_in = cnt_m1;
         iiea_pkg::CNT_CLEAR: cnt_in = '0;
         default:             cnt_in = cnt_ff;
      endcase
      case (cmd.ptr_op)
         iiea_pkg::PTR_CNT_M1: ptr_in = cnt_m1;
         iiea_pkg::PTR_IDX_P1: ptr_in = idx_p1;
         iiea_pkg::PTR_DEC:    ptr_in = ptr_m1;
         iiea_pkg::PTR_INC:    ptr_in = ptr_p1;
         default:              ptr_in = ptr_ff;
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         func_ff <= req_func;
         idx_ff  <= req_index;
         val_ff  <= iiea_pkg::WORD_BITS'(req_value);
      end
      if (cmd.note_en) begin
         status_ff    <= cmd.status;
         use_rdata_ff <= cmd.use_rdata;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff   <= use_rdata_ff ? iiea_pkg::DATA_W'(rdata_ff) : '0;
         rsp_status_ff <= status_ff;
         rsp_length_ff <= iiea_pkg::LEN_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   // The index is compared at its full width, so indexes above the length
   // report out of bound even when they exceed the depth.
   always_comb begin
      sts.func       = func_ff;
      sts.full       = (cnt_ff == CW'(iiea_pkg::DEPTH));
      sts.empty      = (cnt_ff == '0);
      sts.idx_gt_cnt = (idx_ff > cnt_ff);
      sts.idx_ge_cnt = (idx_ff >= cnt_ff);
      sts.idx_eq_cnt = (idx_ff == cnt_ff);
      sts.idx_last   = (idx_p1 == cnt_ff);
      sts.ptr_eq_idx = (ptr_ff == idx_w);
      sts.ptr_last   = (ptr_p1 == cnt_ff);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_is_empty = rsp_empty_ff;

endmodule

@@ test/word_array_checker.sv @@
// Checker for the indexed insert/erase word array: watches both channels,
// predicts every result from its own copy of the array and compares them.
// Depends on iiea_pkg, iiea_req_if and iiea_rsp_if.
module word_array_checker
   import iiea_pkg::*;
(
   input  logic clock,
   input  logic reset,
   iiea_req_if  req_ch,
   iiea_rsp_if  rsp_ch,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
      logic                is_empty;
   } array_result_type;

   word_type         words [DEPTH];
   int unsigned      fill = 0;
   array_result_type pending_results [$];
   int               errors = 0;
   int               waiting = 0;

   assign fail_count  = errors;
   assign outstanding = waiting;

   // Applies one operation to the local array and returns what the block must answer.
   function automatic array_result_type step_word_array(input logic [FUNC_W-1:0]  op,
                                                        input logic [INDEX_W-1:0] idx,
                                                        input logic [DATA_W-1:0]  val);
      array_result_type res;
      int unsigned      pos;
      res.data   = '0;
      res.status = ST_OK;
      pos = idx;
      case (op)
         FUNC_APPEND: begin
            if (fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               words[fill] = word_type'(val);
               fill++;
            end
         end
         FUNC_POP: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               fill--;
               res.data = DATA_W'(words[fill]);
            end
         end
         FUNC_INSERT: begin
            // The bound check wins over the full check.
            if (pos > fill) begin
               res.status = ST_BOUND;
            end else if (fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int unsigned i = fill; i > pos; i--) words[i] = words[i-1];
               words[pos] = word_type'(val);
               fill++;
            end
         end
         FUNC_ERASE: begin
            if (pos >= fill) begin
               res.status = ST_BOUND;
            end else begin
               for (int unsigned i = pos; i + 1 < fill; i++) words[i] = words[i+1];
               fill--;
            end
         end
         FUNC_READ: begin
            if (pos >= fill) res.status = ST_BOUND;
            else res.data = DATA_W'(words[pos]);
         end
         FUNC_FRONT: begin
            if (fill == 0) res.status = ST_EMPTY;
            else res.data = DATA_W'(words[0]);
         end
         FUNC_BACK: begin
            if (fill == 0) res.status = ST_EMPTY;
            else res.data = DATA_W'(words[fill-1]);
         end
         default: begin
            fill = 0;
         end
      endcase
      res.length   = LEN_W'(fill);
      res.is_empty = (fill == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      array_result_type want;
      array_result_type predicted;
      if (reset) begin
         pending_results.delete();
         fill    = 0;
         waiting = 0;
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            predicted = step_word_array(req_ch.func, req_ch.index, req_ch.value);
            pending_results.insert(pending_results.size(), predicted);
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               errors++;
               $error("result item with nothing outstanding: data %0h status %0d",
                      rsp_ch.data, rsp_ch.status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.data !== want.data) begin
                  errors++;
                  $error("data: expected %0h, got %0h", want.data, rsp_ch.data);
               end
               if (rsp_ch.status !== want.status) begin
                  errors++;
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               end
               if (rsp_ch.length !== want.length) begin
                  errors++;
                  $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
               end
               if (rsp_ch.is_empty !== want.is_empty) begin
                  errors++;
                  $error("is_empty: expected %0d, got %0d", want.is_empty,
                         rsp_ch.is_empty);
               end
            end
         end
         waiting = pending_results.size();
      end
   end

endmodule

@@ test/tb.sv @@
// Top of the testbench for the indexed insert/erase word array: clock, reset,
// directed and random items, result-side stalls and the verdict.
// Depends on iiea_pkg, both channel interfaces, the block and word_array_checker.
module tb;
   import iiea_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   bit   gaps_on = 1'b1;
   int   fill_est = 0;
   int   fail_count;
   int   outstanding;

   iiea_req_if req_ch ();
   iiea_rsp_if rsp_ch ();

   indexed_insert_erase_array dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   word_array_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: stalls at random unless the quiet stretch is running.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 35);
      end
   end

   // Valid stays high from one item to the next unless a gap is taken first.
   task automatic send_item(input logic [FUNC_W-1:0]  op,
                            input logic [INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0]  val);
      if (gaps_on && $urandom_range(0, 99) < 35) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (gaps_on && $urandom_range(0, 99) < 35) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op;
      req_ch.index <= idx;
      req_ch.value <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // Rough length tracking, used only to steer the random items.
      case (op)
         FUNC_APPEND: if (fill_est < DEPTH) fill_est++;
         FUNC_POP:    if (fill_est > 0) fill_est--;
         FUNC_INSERT: if (idx <= fill_est && fill_est < DEPTH) fill_est++;
         FUNC_ERASE:  if (idx < fill_est) fill_est--;
         FUNC_CLEAR:  fill_est = 0;
         default:     ;
      endcase
   endtask

   // Mostly an index that succeeds (up to last_ok), sometimes any 7-bit index.
   function automatic logic [INDEX_W-1:0] pick_index(input int last_ok);
      if (last_ok < 0 || $urandom_range(0, 99) < 15)
         return INDEX_W'($urandom_range(0, 127));
      return INDEX_W'($urandom_range(0, last_ok));
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input bit growing);
      int r;
      r = $urandom_range(0, 99);
      if (growing) begin
         if (r < 30) return FUNC_APPEND;
         if (r < 55) return FUNC_INSERT;
         if (r < 65) return FUNC_ERASE;
         if (r < 70) return FUNC_POP;
         if (r < 86) return FUNC_READ;
         if (r < 93) return FUNC_FRONT;
         return FUNC_BACK;
      end
      if (r < 8)  return FUNC_APPEND;
      if (r < 15) return FUNC_INSERT;
      if (r < 45) return FUNC_ERASE;
      if (r < 63) return FUNC_POP;
      if (r < 83) return FUNC_READ;
      if (r < 89) return FUNC_FRONT;
      if (r < 97) return FUNC_BACK;
      return FUNC_CLEAR;
   endfunction

   initial begin
      logic [FUNC_W-1:0]  op;
      logic [INDEX_W-1:0] idx;
      bit                 growing;
      int                 full_hits;
      growing   = 1'b1;
      full_hits = 0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= FUNC_APPEND;
      req_ch.index <= '0;
      req_ch.value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every failing case on an empty array first.
      send_item(FUNC_POP,    7'd0,   32'h0);
      send_item(FUNC_FRONT,  7'd0,   32'h0);
      send_item(FUNC_BACK,   7'd0,   32'h0);
      send_item(FUNC_READ,   7'd0,   32'h0);
      send_item(FUNC_ERASE,  7'd0,   32'h0);
      send_item(FUNC_INSERT, 7'd1,   32'h1234_5678);
      // Insert at the length behaves as an append.
      send_item(FUNC_INSERT, 7'd0,   32'h0000_0000);
      send_item(FUNC_APPEND, 7'd127, 32'hFFFF_FFFF);
      send_item(FUNC_INSERT, 7'd1,   32'hA5A5_5A5A);
      send_item(FUNC_INSERT, 7'd0,   32'h8000_0001);
      send_item(FUNC_READ,   7'd2,   32'h0);
      send_item(FUNC_FRONT,  7'd0,   32'h0);
      send_item(FUNC_BACK,   7'd0,   32'h0);
      send_item(FUNC_READ,   7'd127, 32'h0);
      send_item(FUNC_READ,   7'd4,   32'h0);
      send_item(FUNC_ERASE,  7'd4,   32'h0);
      send_item(FUNC_INSERT, 7'd64,  32'h0);
      send_item(FUNC_ERASE,  7'd1,   32'h0);
      send_item(FUNC_ERASE,  7'd2,   32'h0);
      send_item(FUNC_POP,    7'd0,   32'h0);
      send_item(FUNC_CLEAR,  7'd0,   32'h0);
      send_item(FUNC_CLEAR,  7'd0,   32'h0);
      send_item(FUNC_BACK,   7'd0,   32'h0);

      // Random part: fill towards full, linger there, then drain towards empty.
      for (int n = 0; n < 1850; n++) begin
         gaps_on = !(n >= 700 && n < 1000);
         op = pick_func(growing);
         case (op)
            FUNC_INSERT:           idx = pick_index(fill_est);
            FUNC_ERASE, FUNC_READ: idx = pick_index(fill_est - 1);
            default:               idx = INDEX_W'($urandom_range(0, 127));
         endcase
         send_item(op, idx, DATA_W'($urandom()));
         if (growing && fill_est == DEPTH) full_hits++;
         if (growing && full_hits >= 6) begin
            growing   = 1'b0;
            full_hits = 0;
         end else if (!growing && fill_est == 0) begin
            growing = 1'b1;
         end else if ($urandom_range(0, 99) < 1) begin
            growing = !growing;
         end
      end
      req_ch.valid <= 1'b0;

      // Let the checker count the last item before waiting on outstanding ones.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
